// File: rtl/core/tcfof_pkg.sv
// Package for the two-class oldest-first FIFO: entry type, control and
// status structs, operation and status codes. No dependencies.
`default_nettype none

package tcfof_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_ENQUEUE   = 2'd0;
  localparam logic [1:0] OP_ADOPT_DOG = 2'd1;
  localparam logic [1:0] OP_ADOPT_CAT = 2'd2;
  localparam logic [1:0] OP_ADOPT_ANY = 2'd3;

  // Result status codes carried in the output tuser.
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_ADOPTED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Animal classes.
  localparam logic CLASS_DOG = 1'b0;
  localparam logic CLASS_CAT = 1'b1;

  // Arrival date packed so that an unsigned compare is chronological.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // One queue entry.
  typedef struct packed {
    logic [63:0] name_lo;
    logic [7:0]  name_hi;
    date_t       date;
  } entry_t;

  // Control from the top level to one queue.
  typedef struct packed {
    logic enq;
    logic deq;
  } q_ctl_t;

  // Status from one queue to the top level.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/tcfof_cell.sv
// One storage cell of the shifting queue chain.
// Depends on tcfof_pkg for the entry type.
`default_nettype none

module tcfof_cell (
  input  wire logic             clk,
  input  wire logic             shift,      // take the neighbor's entry
  input  wire logic             load,       // take the new entry
  input  wire tcfof_pkg::entry_t load_data,
  input  wire tcfof_pkg::entry_t next_data, // entry of the cell behind this one
  output tcfof_pkg::entry_t      data
);

  tcfof_pkg::entry_t data_r;
  tcfof_pkg::entry_t data_nxt;

  // A dequeue moves every entry one cell toward the head; an enqueue
  // fills only the cell at the current fill level.
  always_comb begin
    data_nxt = data_r;
    if (shift) begin
      data_nxt = next_data;
    end else if (load) begin
      data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: rtl/core/tcfof_queue.sv
// One bounded FIFO built as a chain of cells with the head in cell zero.
// Depends on tcfof_pkg and tcfof_cell.
`default_nettype none

module tcfof_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcfof_pkg::q_ctl_t  ctl,
  input  wire tcfof_pkg::entry_t  wr_entry,
  output tcfof_pkg::entry_t       head,
  output tcfof_pkg::q_stat_t      stat
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  tcfof_pkg::entry_t cell_data [QUEUE_DEPTH];

  // Fill level: an enqueue never meets a dequeue on the same queue.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.enq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.deq) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // The chain of cells; the last one shifts in a blank entry.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tcfof_pkg::entry_t next_data;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end
    tcfof_cell u_cell (
      .clk       (clk),
      .shift     (ctl.deq),
      .load      (ctl.enq && (cnt_r == CNT_W'(i))),
      .load_data (wr_entry),
      .next_data (next_data),
      .data      (cell_data[i])
    );
  end

  assign head       = cell_data[0];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: rtl/core/two_class_fifo_oldest_first_top.sv
// Top level of the two-class oldest-first FIFO: op decode, head compare
// and output register. Depends on tcfof_pkg and tcfof_queue.
//
//   channel | direction | tdata                       | tuser
//   in_     | slave     | name, arrival date (96 bit) | op, pet_class
//   out_    | master     | adopted name (72 bit)       | status, adopted_class
//
// The queue heads sit in cell zero of each chain, so the oldest-first compare
// and the update of both chains finish in the cycle of acceptance, and the
// result lands in the output register.
// A new word is taken while the output register is empty or being drained.
// Reset (synchronous, active low) empties both queues and the output register.
`default_nettype none

module two_class_fifo_oldest_first_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [63:0] name_first_eight, [71:64] name_last_char, [85:72] arrival_year,
  // [89:86] arrival_month, [94:90] arrival_day, [95] zero
  input  wire logic [95:0] in_tdata,
  // [1:0] op, [2] pet_class
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [63:0] adopted_name_first_eight, [71:64] adopted_name_last_char
  output logic [71:0]      out_tdata,
  // [1:0] status, [2] adopted_class
  output logic [2:0]       out_tuser
);

  logic        accept;
  logic [1:0]  op;
  logic        pet_class;
  tcfof_pkg::entry_t  wr_entry;
  tcfof_pkg::entry_t  dog_head;
  tcfof_pkg::entry_t  cat_head;
  tcfof_pkg::q_ctl_t  dog_ctl;
  tcfof_pkg::q_ctl_t  cat_ctl;
  tcfof_pkg::q_stat_t dog_stat;
  tcfof_pkg::q_stat_t cat_stat;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  status_r;
  logic [1:0]  status_nxt;
  logic        class_r;
  logic        class_nxt;
  logic [63:0] name_lo_r;
  logic [63:0] name_lo_nxt;
  logic [7:0]  name_hi_r;
  logic [7:0]  name_hi_nxt;

  // Unpack the input word.
  assign op                  = in_tuser[1:0];
  assign pet_class           = in_tuser[2];
  assign wr_entry.name_lo    = in_tdata[63:0];
  assign wr_entry.name_hi    = in_tdata[71:64];
  assign wr_entry.date.year  = in_tdata[85:72];
  assign wr_entry.date.month = in_tdata[89:86];
  assign wr_entry.date.day   = in_tdata[94:90];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Decode the operation, choose the queue and build the result.
  always_comb begin
    logic take_dog;
    logic take_cat;
    take_dog    = 1'b0;
    take_cat    = 1'b0;
    dog_ctl     = '0;
    cat_ctl     = '0;
    status_nxt  = tcfof_pkg::ST_EMPTY;
    case (op)
      tcfof_pkg::OP_ENQUEUE: begin
        if (pet_class == tcfof_pkg::CLASS_DOG) begin
          dog_ctl.enq = accept && !dog_stat.full;
          status_nxt  = dog_stat.full ? tcfof_pkg::ST_FULL : tcfof_pkg::ST_ENQUEUED;
        end else begin
          cat_ctl.enq = accept && !cat_stat.full;
          status_nxt  = cat_stat.full ? tcfof_pkg::ST_FULL : tcfof_pkg::ST_ENQUEUED;
        end
      end
      tcfof_pkg::OP_ADOPT_DOG: take_dog = !dog_stat.empty;
      tcfof_pkg::OP_ADOPT_CAT: take_cat = !cat_stat.empty;
      tcfof_pkg::OP_ADOPT_ANY: begin
        // Older head wins; equal dates go to the dog.
        if (!dog_stat.empty && !cat_stat.empty) begin
          take_dog = (dog_head.date <= cat_head.date);
          take_cat = !take_dog;
        end else begin
          take_dog = !dog_stat.empty;
          take_cat = !cat_stat.empty;
        end
      end
      default: begin
        take_dog = 1'b0;
      end
    endcase

    dog_ctl.deq = accept && take_dog;
    cat_ctl.deq = accept && take_cat;

    class_nxt   = 1'b0;
    name_lo_nxt = '0;
    name_hi_nxt = '0;
    if (take_dog) begin
      status_nxt  = tcfof_pkg::ST_ADOPTED;
      class_nxt   = tcfof_pkg::CLASS_DOG;
      name_lo_nxt = dog_head.name_lo;
      name_hi_nxt = dog_head.name_hi;
    end else if (take_cat) begin
      status_nxt  = tcfof_pkg::ST_ADOPTED;
      class_nxt   = tcfof_pkg::CLASS_CAT;
      name_lo_nxt = cat_head.name_lo;
      name_hi_nxt = cat_head.name_hi;
    end
  end

  tcfof_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dog_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dog_ctl),
    .wr_entry (wr_entry),
    .head     (dog_head),
    .stat     (dog_stat)
  );

  tcfof_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_cat_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cat_ctl),
    .wr_entry (wr_entry),
    .head     (cat_head),
    .stat     (cat_stat)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on each accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      class_r   <= class_nxt;
      name_lo_r <= name_lo_nxt;
      name_hi_r <= name_hi_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {name_hi_r, name_lo_r};
  assign out_tuser  = {class_r, status_r};

endmodule

`default_nettype wire
